// ----- sv/soii_pkg.sv -----
package soii_pkg;

    // Geometry and arithmetic limits
    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 1024;
    localparam int MAX_FEATURES = 4;
    localparam int FEATURE_BITS = 16;
    localparam int MAX_PAIRS    = (MAX_FEATURES * (MAX_FEATURES + 1)) / 2;

    localparam int X_W      = $clog2(MAX_WIDTH);
    localparam int Y_W      = $clog2(MAX_HEIGHT);
    localparam int DIM_W    = 11;
    localparam int FCNT_W   = 3;
    localparam int FIDX_W   = 2;
    localparam int PAIR_W   = $clog2(MAX_PAIRS);
    localparam int PROD_W   = 2 * FEATURE_BITS;
    localparam int SUM_W    = 52;
    localparam int OUT_W    = 53;

    // Line store of previous-row integrals
    localparam int LINE_DEPTH = MAX_WIDTH * MAX_PAIRS;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);

    // Result queue
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CW    = OUTQ_AW + 1;

    // APB register map
    localparam int CFG_AW     = 4;
    localparam int CFG_DW     = 32;

    typedef enum logic [1:0] {
        REG_WIDTH    = 2'd0,
        REG_HEIGHT   = 2'd1,
        REG_FEATURES = 2'd2
    } t_reg_idx;

    // Effective geometry plus frame restart strobe
    typedef struct packed {
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [FCNT_W-1:0] features;
        logic              restart;
    } t_cfg;

    // One pair issued by the sequencer
    typedef struct packed {
        logic                     valid;
        logic [LINE_AW-1:0]       addr;
        logic signed [PROD_W-1:0] prod;
        logic                     first_row;
        logic                     row_start;
        logic [PAIR_W-1:0]        pair;
        logic [FIDX_W-1:0]        fi;
        logic [FIDX_W-1:0]        fj;
        logic [X_W-1:0]           x;
        logic [Y_W-1:0]           y;
        logic                     last;
    } t_issue;

    // One finished result
    typedef struct packed {
        logic [DIM_W-1:0]        column;
        logic [DIM_W-1:0]        row;
        logic [FIDX_W-1:0]       first_feature;
        logic [FIDX_W-1:0]       second_feature;
        logic signed [OUT_W-1:0] pair_sum;
        logic                    last_of_pixel;
    } t_res;

    typedef struct packed {
        logic valid;
        t_res res;
    } t_push;

    // Occupancy of the accumulate pipeline
    typedef struct packed {
        logic s1_valid;
        logic s2_valid;
    } t_acc_stat;

endpackage

// ----- sv/soii_if.sv -----
interface soii_pix_if;
    import soii_pkg::*;
    logic                           valid;
    logic                           ready;
    logic signed [FEATURE_BITS-1:0] feature_0;
    logic signed [FEATURE_BITS-1:0] feature_1;
    logic signed [FEATURE_BITS-1:0] feature_2;
    logic signed [FEATURE_BITS-1:0] feature_3;

    modport source (output valid, feature_0, feature_1, feature_2, feature_3, input ready);
    modport sink   (input valid, feature_0, feature_1, feature_2, feature_3, output ready);
endinterface

interface soii_res_if;
    import soii_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [DIM_W-1:0]        column;
    logic [DIM_W-1:0]        row;
    logic [FIDX_W-1:0]       first_feature;
    logic [FIDX_W-1:0]       second_feature;
    logic signed [OUT_W-1:0] pair_sum;
    logic                    last_of_pixel;

    modport source (output valid, column, row, first_feature, second_feature, pair_sum,
                    last_of_pixel, input ready);
    modport sink   (input valid, column, row, first_feature, second_feature, pair_sum,
                    last_of_pixel, output ready);
endinterface

// ----- sv/soii_ram.sv -----
module soii_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port (old data on collision)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end
endmodule

// ----- sv/soii_cfg.sv -----
module soii_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [soii_pkg::CFG_AW-1:0]  paddr,
    input  logic [soii_pkg::CFG_DW-1:0]  pwdata,
    output logic [soii_pkg::CFG_DW-1:0]  prdata,
    output logic                         pready,
    output soii_pkg::t_cfg               o_cfg
);
    import soii_pkg::*;

    logic [DIM_W-1:0]  r_width;
    logic [DIM_W-1:0]  r_height;
    logic [FCNT_W-1:0] r_features;
    logic              wr;
    t_reg_idx          idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = t_reg_idx'(paddr[3:2]);

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= DIM_W'(MAX_WIDTH);
            r_height   <= DIM_W'(MAX_HEIGHT);
            r_features <= FCNT_W'(MAX_FEATURES);
        end else if (wr) begin
            unique case (idx)
                REG_WIDTH:    r_width    <= pwdata[DIM_W-1:0];
                REG_HEIGHT:   r_height   <= pwdata[DIM_W-1:0];
                REG_FEATURES: r_features <= pwdata[FCNT_W-1:0];
                default:      ;
            endcase
        end
    end

    // Read-back
    always_comb begin
        unique case (idx)
            REG_WIDTH:    prdata = CFG_DW'(r_width);
            REG_HEIGHT:   prdata = CFG_DW'(r_height);
            REG_FEATURES: prdata = CFG_DW'(r_features);
            default:      prdata = '0;
        endcase
    end

    // Clamp to usable geometry; any write restarts the frame
    always_comb begin
        if (r_width == '0)                        o_cfg.width = DIM_W'(1);
        else if (r_width > DIM_W'(MAX_WIDTH))     o_cfg.width = DIM_W'(MAX_WIDTH);
        else                                      o_cfg.width = r_width;
        if (r_height == '0)                       o_cfg.height = DIM_W'(1);
        else if (r_height > DIM_W'(MAX_HEIGHT))   o_cfg.height = DIM_W'(MAX_HEIGHT);
        else                                      o_cfg.height = r_height;
        if (r_features == '0)                     o_cfg.features = FCNT_W'(1);
        else if (r_features > FCNT_W'(MAX_FEATURES)) o_cfg.features = FCNT_W'(MAX_FEATURES);
        else                                      o_cfg.features = r_features;
        o_cfg.restart = wr;
    end
endmodule

// ----- sv/soii_seq.sv -----
module soii_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    soii_pix_if.sink        i_pix,
    input  soii_pkg::t_cfg  i_cfg,
    input  logic            i_credit_ok,
    output soii_pkg::t_issue o_iss
);
    import soii_pkg::*;

    logic                           r_busy;
    logic signed [FEATURE_BITS-1:0] r_feat [MAX_FEATURES];
    logic [X_W-1:0]                 r_x;
    logic [Y_W-1:0]                 r_y;
    logic [X_W-1:0]                 r_cx;
    logic [Y_W-1:0]                 r_cy;
    logic [PAIR_W-1:0]              r_p;
    logic [FIDX_W-1:0]              r_i;
    logic [FIDX_W-1:0]              r_j;

    logic              issue;
    logic              last_pair;
    logic              accept;
    logic [FCNT_W-1:0] dm1;
    logic [DIM_W-1:0]  cx_inc;
    logic [DIM_W-1:0]  cy_inc;

    assign dm1       = i_cfg.features - FCNT_W'(1);
    assign last_pair = ({1'b0, r_i} == dm1);
    assign issue     = r_busy && i_credit_ok;
    assign i_pix.ready = !r_busy || (issue && last_pair);
    assign accept    = i_pix.valid && i_pix.ready;
    assign cx_inc    = DIM_W'(r_cx) + DIM_W'(1);
    assign cy_inc    = DIM_W'(r_cy) + DIM_W'(1);

    // Control: pixel hold, pair walk, raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cx   <= '0;
            r_cy   <= '0;
            r_p    <= '0;
            r_i    <= '0;
            r_j    <= '0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
                r_p    <= '0;
                r_i    <= '0;
                r_j    <= '0;
            end else if (issue) begin
                if (last_pair) begin
                    r_busy <= 1'b0;
                end
                r_p <= r_p + PAIR_W'(1);
                if ({1'b0, r_j} == dm1) begin
                    r_i <= r_i + FIDX_W'(1);
                    r_j <= r_i + FIDX_W'(1);
                end else begin
                    r_j <= r_j + FIDX_W'(1);
                end
            end
            if (i_cfg.restart) begin
                r_cx <= '0;
                r_cy <= '0;
            end else if (accept) begin
                if (cx_inc >= i_cfg.width) begin
                    r_cx <= '0;
                    r_cy <= (cy_inc >= i_cfg.height) ? '0 : cy_inc[Y_W-1:0];
                end else begin
                    r_cx <= cx_inc[X_W-1:0];
                end
            end
        end
    end

    // Pixel payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_feat[0] <= i_pix.feature_0;
            r_feat[1] <= i_pix.feature_1;
            r_feat[2] <= i_pix.feature_2;
            r_feat[3] <= i_pix.feature_3;
            r_x       <= r_cx;
            r_y       <= r_cy;
        end
    end

    // Issue one pair: product and line-store slot
    always_comb begin
        o_iss.valid     = issue;
        o_iss.addr      = LINE_AW'(r_x) * LINE_AW'(MAX_PAIRS) + LINE_AW'(r_p);
        o_iss.prod      = r_feat[r_i] * r_feat[r_j];
        o_iss.first_row = (r_y == '0);
        o_iss.row_start = (r_x == '0);
        o_iss.pair      = r_p;
        o_iss.fi        = r_i;
        o_iss.fj        = r_j;
        o_iss.x         = r_x;
        o_iss.y         = r_y;
        o_iss.last      = last_pair;
    end
endmodule

// ----- sv/soii_acc.sv -----
module soii_acc (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  soii_pkg::t_issue   i_iss,
    output soii_pkg::t_push    o_push,
    output soii_pkg::t_acc_stat o_stat
);
    import soii_pkg::*;

    // Stage 1: line data back, row sum update
    logic                     r_s1_valid;
    t_issue                   r_s1;
    // Stage 2: final add, write-back
    logic                     r_s2_valid;
    t_issue                   r_s2;
    logic [SUM_W-1:0]         r_s2_run;
    logic [SUM_W-1:0]         r_s2_above;
    // Write from the previous cycle, for forwarding
    logic                     r_wp_valid;
    logic [LINE_AW-1:0]       r_wp_addr;
    logic [SUM_W-1:0]         r_wp_data;
    // Per-pair running row sums
    logic [SUM_W-1:0]         r_run [MAX_PAIRS];

    logic [SUM_W-1:0]         ram_rd;
    logic [SUM_W-1:0]         base;
    logic [SUM_W-1:0]         n_run;
    logic [SUM_W-1:0]         fwd;
    logic [SUM_W-1:0]         n_above;
    logic signed [OUT_W-1:0]  val;

    soii_ram #(
        .WIDTH (SUM_W),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (r_s2_valid),
        .i_waddr (r_s2.addr),
        .i_wdata (val[SUM_W-1:0]),
        .i_re    (i_iss.valid),
        .i_raddr (i_iss.addr),
        .o_rdata (ram_rd)
    );

    // Stage 1 datapath: row sum restarts at column zero
    always_comb begin
        base  = r_s1.row_start ? '0 : r_run[r_s1.pair];
        n_run = base + {{(SUM_W-PROD_W){r_s1.prod[PROD_W-1]}}, r_s1.prod};
        if (r_s2_valid && (r_s2.addr == r_s1.addr)) begin
            fwd = val[SUM_W-1:0];
        end else if (r_wp_valid && (r_wp_addr == r_s1.addr)) begin
            fwd = r_wp_data;
        end else begin
            fwd = ram_rd;
        end
        n_above = r_s1.first_row ? '0 : fwd;
    end

    // Stage 2 datapath
    assign val = {r_s2_above[SUM_W-1], r_s2_above} + {r_s2_run[SUM_W-1], r_s2_run};

    // Pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_wp_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_iss.valid;
            r_s2_valid <= r_s1_valid;
            r_wp_valid <= r_s2_valid;
        end
    end

    // Pipeline payload and row sums
    always_ff @(posedge i_clk) begin
        r_s1       <= i_iss;
        r_s2       <= r_s1;
        r_s2_run   <= n_run;
        r_s2_above <= n_above;
        r_wp_addr  <= r_s2.addr;
        r_wp_data  <= val[SUM_W-1:0];
        if (r_s1_valid) begin
            r_run[r_s1.pair] <= n_run;
        end
    end

    always_comb begin
        o_push.valid              = r_s2_valid;
        o_push.res.column         = DIM_W'(r_s2.x) + DIM_W'(1);
        o_push.res.row            = DIM_W'(r_s2.y) + DIM_W'(1);
        o_push.res.first_feature  = r_s2.fi;
        o_push.res.second_feature = r_s2.fj;
        o_push.res.pair_sum       = val;
        o_push.res.last_of_pixel  = r_s2.last;
        o_stat.s1_valid           = r_s1_valid;
        o_stat.s2_valid           = r_s2_valid;
    end
endmodule

// ----- sv/soii_outq.sv -----
module soii_outq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  soii_pkg::t_push               i_push,
    soii_res_if.source                    o_res,
    output logic [soii_pkg::OUTQ_CW-1:0]  o_count
);
    import soii_pkg::*;

    t_res                r_mem [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0]  r_wptr;
    logic [OUTQ_AW-1:0]  r_rptr;
    logic [OUTQ_CW-1:0]  r_count;
    logic                pop;
    t_res                head;

    assign pop     = o_res.valid && o_res.ready;
    assign head    = r_mem[r_rptr];
    assign o_count = r_count;

    // Pointers and fill level; issue credit keeps pushes from overflowing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push.valid) begin
                r_wptr <= r_wptr + OUTQ_AW'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + OUTQ_AW'(1);
            end
            r_count <= r_count + OUTQ_CW'(i_push.valid) - OUTQ_CW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wptr] <= i_push.res;
        end
    end

    // Result beat
    always_comb begin
        o_res.valid          = (r_count != '0);
        o_res.column         = head.column;
        o_res.row            = head.row;
        o_res.first_feature  = head.first_feature;
        o_res.second_feature = head.second_feature;
        o_res.pair_sum       = head.pair_sum;
        o_res.last_of_pixel  = head.last_of_pixel;
    end
endmodule

// ----- sv/second_order_integral_image.sv -----
// Throughput: one result beat per cycle while queue credit and the receiver allow; a
// pixel with d features gives d*(d+1)/2 pairs (1 to 10), issued one at a time through
// the single read/write port pair of the line store.
// Reset (synchronous, active low): counters, pipeline and queue cleared, geometry back to
// 1024x1024 with 4 features. The line store is not cleared; row 0 ignores what it reads.
module second_order_integral_image (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    soii_pix_if.sink                     i_pix,
    soii_res_if.source                   o_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [soii_pkg::CFG_AW-1:0]  paddr,
    input  logic [soii_pkg::CFG_DW-1:0]  pwdata,
    output logic [soii_pkg::CFG_DW-1:0]  prdata,
    output logic                         pready
);
    import soii_pkg::*;

    t_cfg               cfg;
    t_issue             iss;
    t_push              push;
    t_acc_stat          stat;
    logic [OUTQ_CW-1:0] q_count;
    logic [OUTQ_CW:0]   committed;
    logic               credit_ok;

    // Issue only when every pair in flight has a queue slot
    assign committed = (OUTQ_CW+1)'(q_count) + (OUTQ_CW+1)'(stat.s1_valid)
                     + (OUTQ_CW+1)'(stat.s2_valid);
    assign credit_ok = committed < (OUTQ_CW+1)'(OUTQ_DEPTH);

    soii_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    soii_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (i_pix),
        .i_cfg       (cfg),
        .i_credit_ok (credit_ok),
        .o_iss       (iss)
    );

    soii_acc u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_iss   (iss),
        .o_push  (push),
        .o_stat  (stat)
    );

    soii_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_res   (o_res),
        .o_count (q_count)
    );
endmodule

// ----- tb/tb_top.sv -----
module tb_top;
    import soii_pkg::*;

    localparam int CYCLE_LIMIT  = 400_000;
    localparam int DRAIN_CYCLES = 20;
    // Index past the register list: writes there only restart the frame
    localparam int REG_UNMAPPED = 3;

    typedef logic signed [FEATURE_BITS-1:0] t_feat;
    typedef struct packed {
        t_feat f3;
        t_feat f2;
        t_feat f1;
        t_feat f0;
    } t_pixel;

    localparam t_feat FEAT_MAX = 16'sh7FFF;
    localparam t_feat FEAT_MIN = 16'sh8000;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    soii_pix_if pix_if();
    soii_res_if res_if();

    second_order_integral_image u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // Pixels waiting to be sent, pair sums waiting to arrive
    t_pixel      pixel_q[$];
    t_res        expected_q[$];
    t_pixel      next_pixel;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int          mismatches = 0;
    int unsigned cycle_cnt = 0;

    // Predictor copy of the registers and the integral state
    logic [DIM_W-1:0]  cfg_width;
    logic [DIM_W-1:0]  cfg_height;
    logic [FCNT_W-1:0] cfg_features;
    logic [SUM_W-1:0]  line_sums [LINE_DEPTH];
    logic [SUM_W-1:0]  row_sums [MAX_PAIRS];
    int unsigned       col_pos;
    int unsigned       row_pos;

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void restart_frame();
        foreach (row_sums[k]) row_sums[k] = '0;
        col_pos = 0;
        row_pos = 0;
    endfunction

    function automatic void apply_reg_write(input logic [CFG_AW-1:0] addr,
                                            input logic [CFG_DW-1:0] data);
        case (addr[CFG_AW-1:2])
            REG_WIDTH:    cfg_width    = data[DIM_W-1:0];
            REG_HEIGHT:   cfg_height   = data[DIM_W-1:0];
            REG_FEATURES: cfg_features = data[FCNT_W-1:0];
            default: ;
        endcase
        restart_frame();
    endfunction

    // Add one pixel to the integrals and queue its pair sums in pair order
    function automatic void integrate_pixel(input t_feat feat [MAX_FEATURES]);
        int unsigned w;
        int unsigned h;
        int unsigned d;
        int unsigned p;
        int unsigned slot;
        longint      prod;
        longint      above;
        longint      total;
        t_res        r;
        w = clamp_dim(cfg_width, MAX_WIDTH);
        h = clamp_dim(cfg_height, MAX_HEIGHT);
        d = clamp_dim(cfg_features, MAX_FEATURES);
        if (col_pos == 0) foreach (row_sums[k]) row_sums[k] = '0;
        p = 0;
        for (int i = 0; i < d; i++) begin
            for (int j = i; j < d; j++) begin
                prod = longint'(feat[i]) * longint'(feat[j]);
                row_sums[p] = row_sums[p] + prod[SUM_W-1:0];
                slot = col_pos * MAX_PAIRS + p;
                // first row sees zero above and never reads the line store
                above = 0;
                if (row_pos != 0) above = longint'($signed(line_sums[slot]));
                total = above + longint'($signed(row_sums[p]));
                line_sums[slot] = total[SUM_W-1:0];
                r.column         = DIM_W'(col_pos + 1);
                r.row            = DIM_W'(row_pos + 1);
                r.first_feature  = FIDX_W'(i);
                r.second_feature = FIDX_W'(j);
                r.pair_sum       = total[OUT_W-1:0];
                r.last_of_pixel  = (i == d - 1) && (j == d - 1);
                expected_q.push_back(r);
                p++;
            end
        end
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
        end
    endfunction

    function automatic void compare_field(input string name,
                                          input logic signed [63:0] want,
                                          input logic signed [63:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_beat();
        t_res want;
        if (expected_q.size() == 0) begin
            $display("%0t: result beat expected none actual column %0d row %0d",
                     $time, res_if.column, res_if.row);
            $display("    pair (%0d,%0d) sum %0d", res_if.first_feature,
                     res_if.second_feature, res_if.pair_sum);
            mismatches++;
            return;
        end
        want = expected_q.pop_front();
        compare_field("column", want.column, res_if.column);
        compare_field("row", want.row, res_if.row);
        compare_field("first_feature", want.first_feature, res_if.first_feature);
        compare_field("second_feature", want.second_feature, res_if.second_feature);
        compare_field("pair_sum", $signed(want.pair_sum), $signed(res_if.pair_sum));
        compare_field("last_of_pixel", want.last_of_pixel, res_if.last_of_pixel);
    endfunction

    // Pixel driver: holds a beat until taken, then maybe idles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_if.valid <= 1'b0;
        end else if (!pix_if.valid || pix_if.ready) begin
            if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_pixel = pixel_q.pop_front();
                pix_if.valid     <= 1'b1;
                pix_if.feature_0 <= next_pixel.f0;
                pix_if.feature_1 <= next_pixel.f1;
                pix_if.feature_2 <= next_pixel.f2;
                pix_if.feature_3 <= next_pixel.f3;
            end else begin
                pix_if.valid <= 1'b0;
            end
        end
    end

    // Monitor: tracks register writes and pixel beats, checks result beats
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            cfg_width    = DIM_W'(MAX_WIDTH);
            cfg_height   = DIM_W'(MAX_HEIGHT);
            cfg_features = FCNT_W'(MAX_FEATURES);
            restart_frame();
        end else begin
            if (psel && penable && pwrite && pready) apply_reg_write(paddr, pwdata);
            if (pix_if.valid && pix_if.ready)
                integrate_pixel('{pix_if.feature_0, pix_if.feature_1,
                                  pix_if.feature_2, pix_if.feature_3});
            if (res_if.valid && res_if.ready) check_beat();
            res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Sampled on the falling edge so queue updates of the rising edge are settled
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pixel_q.size() != 0 || pix_if.valid || expected_q.size() != 0);
    endtask

    task automatic apb_write(input int idx, input logic [CFG_DW-1:0] value);
        wait_drained();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'(4 * idx);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic queue_pixel(input t_feat a, input t_feat b, input t_feat c, input t_feat d);
        pixel_q.push_back(t_pixel'({d, c, b, a}));
    endtask

    // Mostly full-range values, with the two extremes now and then
    function automatic t_feat rand_feature();
        logic [31:0] r;
        r = $urandom;
        case (r[31:29])
            3'd0:    return FEAT_MIN;
            3'd1:    return FEAT_MAX;
            default: return r[FEATURE_BITS-1:0];
        endcase
    endfunction

    task automatic queue_random(input int n);
        repeat (n) queue_pixel(rand_feature(), rand_feature(), rand_feature(), rand_feature());
    endtask

    // Small random geometry; the sender holds off mid-way until all sums are back
    task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                             input int n);
        apb_write(REG_WIDTH, $urandom_range(1, 6));
        apb_write(REG_HEIGHT, $urandom_range(1, 5));
        apb_write(REG_FEATURES, $urandom_range(1, 4));
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        queue_random(n / 2);
        wait_drained();
        queue_random(n - n / 2);
    endtask

    initial begin
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        pix_if.valid     = 1'b0;
        pix_if.feature_0 = '0;
        pix_if.feature_1 = '0;
        pix_if.feature_2 = '0;
        pix_if.feature_3 = '0;
        res_if.ready     = 1'b0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset geometry, first row only: extreme products
        queue_pixel(FEAT_MAX, FEAT_MAX, FEAT_MAX, FEAT_MAX);
        queue_pixel(FEAT_MIN, FEAT_MIN, FEAT_MIN, FEAT_MIN);
        queue_pixel(FEAT_MIN, FEAT_MAX, -16'sd1, 16'sd1);
        queue_pixel('0, '0, '0, '0);

        // Zero width acts as one, oversize feature count as four
        apb_write(REG_WIDTH, 32'd0);
        apb_write(REG_HEIGHT, 32'd3);
        apb_write(REG_FEATURES, 32'd7);
        queue_pixel(FEAT_MIN, FEAT_MIN, FEAT_MAX, FEAT_MAX);
        queue_pixel(FEAT_MIN, FEAT_MIN, FEAT_MAX, FEAT_MAX);
        queue_pixel(FEAT_MAX, 16'sd3, FEAT_MIN, -16'sd7);
        queue_pixel(16'sd1, -16'sd1, 16'sd2, -16'sd2);

        // Oversize width, zero height, zero features; unused channels carry data
        apb_write(REG_WIDTH, 32'd2047);
        apb_write(REG_HEIGHT, 32'd0);
        apb_write(REG_FEATURES, 32'd0);
        queue_pixel(FEAT_MIN, FEAT_MAX, FEAT_MIN, FEAT_MAX);
        queue_pixel(FEAT_MIN, FEAT_MIN, FEAT_MIN, FEAT_MIN);
        queue_pixel(16'sd5, FEAT_MAX, FEAT_MAX, FEAT_MAX);

        // 2x2 frame with junk in the upper data bits, restarted by an unmapped write
        apb_write(REG_WIDTH, 32'hFFFF_F802);
        apb_write(REG_HEIGHT, 32'd2);
        apb_write(REG_FEATURES, 32'hFFFF_FFFA);
        queue_pixel(FEAT_MAX, FEAT_MIN, FEAT_MAX, FEAT_MIN);
        queue_pixel(-16'sd3, 16'sd9, FEAT_MIN, FEAT_MAX);
        queue_pixel(FEAT_MIN, FEAT_MAX, 16'sd1, 16'sd1);
        apb_write(REG_UNMAPPED, 32'hFFFF_FFFF);
        queue_pixel(FEAT_MIN, FEAT_MIN, 16'sd2, 16'sd2);
        queue_pixel(FEAT_MAX, FEAT_MAX, 16'sd2, 16'sd2);
        queue_pixel(-16'sd1, -16'sd1, -16'sd1, -16'sd1);
        queue_pixel(16'sd100, -16'sd200, 16'sd300, -16'sd400);
        queue_pixel(FEAT_MIN, FEAT_MIN, FEAT_MIN, FEAT_MIN);

        // Three features on a 3x2 frame
        apb_write(REG_WIDTH, 32'd3);
        apb_write(REG_HEIGHT, 32'd2);
        apb_write(REG_FEATURES, 32'd3);
        queue_pixel(FEAT_MIN, FEAT_MAX, FEAT_MIN, FEAT_MAX);
        queue_pixel(FEAT_MAX, FEAT_MIN, FEAT_MAX, FEAT_MIN);
        queue_pixel(16'sd7, -16'sd7, 16'sd0, FEAT_MIN);

        // Random phases, one per idling pattern
        run_phase(0, 0, 50);
        run_phase(81, 0, 50);
        run_phase(0, 81, 50);
        run_phase(23, 23, 50);

        wait_drained();
        recv_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/soii_pkg.sv
sv/soii_if.sv
sv/soii_ram.sv
sv/soii_cfg.sv
sv/soii_seq.sv
sv/soii_acc.sv
sv/soii_outq.sv
sv/second_order_integral_image.sv
tb/tb_top.sv
